// ----- rtl/mlpq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the multilevel priority queue: operation and status codes,
// fixed field widths and the register reset value. No dependencies.
package mlpq_pkg;

  localparam int VALUE_W   = 32;
  localparam int LEVEL_W   = 3;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ----- rtl/mlpq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/multilevel_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Multilevel FIFO priority queue, top level. Uses mlpq_pkg and mlpq_ram.
// Every operation gives its one result in the cycle after the start transfer.
// Throughput: one operation per cycle; the entry RAM's single write and single
// read port, with pointers and level flags in flops, set that figure.
// Reset (synchronous, rst_n low): pointers zero, every level empty, length 16,
// busy high until ready_r is set after reset. The receiver cannot stall.
module multilevel_priority_queue_unit
  import mlpq_pkg::*;
#(
  parameter int LEVELS = 8,
  parameter int SLOTS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic [LEVEL_W-1:0]        in_level,
  // result channel, one-cycle strobe
  output logic                      out_strobe,
  output logic signed [VALUE_W-1:0] out_taken_value,
  output logic [LEVEL_W-1:0]        out_taken_level,
  output logic [1:0]                out_status,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  // Widths derived from the parameters.
  localparam int PW    = $clog2(SLOTS);            // slot pointer
  localparam int LVW   = $clog2(LEVELS);           // level index
  localparam int LW    = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;  // length compare
  localparam int DEPTH = LEVELS << PW;             // entry RAM rows
  localparam int AW    = $clog2(DEPTH);

  // ------------------------------------------------------------------
  // Architectural state: pointers and level flags in flops, entries in RAM.
  // ------------------------------------------------------------------
  logic [PW-1:0]    head_r     [LEVELS];
  logic [PW-1:0]    tail_r     [LEVELS];
  logic [LEVELS-1:0] nonempty_r;
  logic [CFG_W-1:0] qlen_r;
  logic             ready_r;

  // Result registers; value comes straight from the RAM read register.
  logic             out_strobe_r;
  logic             out_take_r;
  logic [LEVEL_W-1:0] out_level_r;
  status_t          out_status_r;

  logic             accept;
  assign accept = start & ready_r;
  assign busy   = ~ready_r;

  // Effective length: zero acts as one, anything past SLOTS as SLOTS.
  logic [LW-1:0] qlen_ext;
  logic [LW-1:0] eff_len;
  assign qlen_ext = LW'(qlen_r);
  always_comb begin
    if (qlen_r == '0) begin
      eff_len = LW'(1);
    end else if (qlen_ext > LW'(SLOTS)) begin
      eff_len = LW'(SLOTS);
    end else begin
      eff_len = qlen_ext;
    end
  end

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [LW-1:0] len);
    logic [LW-1:0] n;
    n = LW'(p) + LW'(1);
    if (n >= len) begin
      return '0;
    end
    return n[PW-1:0];
  endfunction

  // ------------------------------------------------------------------
  // Insert path: level decode and full check.
  // ------------------------------------------------------------------
  logic           ins_in_range;
  logic [LVW-1:0] ins_lvl;
  logic           ins_full;
  logic           ins_ok;

  assign ins_in_range = (32'(in_level) < 32'(LEVELS));
  assign ins_lvl      = LVW'(in_level);
  assign ins_full     = nonempty_r[ins_lvl] && (tail_r[ins_lvl] == head_r[ins_lvl]);
  assign ins_ok       = ins_in_range && !ins_full;

  // ------------------------------------------------------------------
  // Remove path: lowest-numbered non-empty level wins.
  // ------------------------------------------------------------------
  logic           rem_found;
  logic [LVW-1:0] rem_lvl;

  always_comb begin
    rem_found = |nonempty_r;
    rem_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        rem_lvl = LVW'(i);
      end
    end
  end

  logic [PW-1:0] rem_head_nxt;
  assign rem_head_nxt = advance(head_r[rem_lvl], eff_len);

  logic do_insert;
  logic do_remove;
  logic is_remove;
  assign is_remove = (func_t'(in_func) == FUNC_REMOVE);
  assign do_insert = accept && !is_remove && ins_ok;
  assign do_remove = accept && is_remove && rem_found;

  // ------------------------------------------------------------------
  // Entry RAM: row = {level, slot}. A write and a read never fall on the
  // same edge, and the read data register holds until the next remove.
  // ------------------------------------------------------------------
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_W-1:0]    ram_rdata;

  assign ram_waddr = AW'({ins_lvl, tail_r[ins_lvl]});
  assign ram_raddr = AW'({rem_lvl, head_r[rem_lvl]});

  mlpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (do_insert),
    .waddr (ram_waddr),
    .wdata (in_item_value),
    .re    (do_remove),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Pointer, flag and config updates.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      nonempty_r <= '0;
      qlen_r     <= CFG_RESET;
      ready_r    <= 1'b0;
    end else begin
      ready_r <= 1'b1;
      if (cfg_we) begin
        qlen_r <= cfg_wdata;
      end
      if (do_insert) begin
        tail_r[ins_lvl]     <= advance(tail_r[ins_lvl], eff_len);
        nonempty_r[ins_lvl] <= 1'b1;
      end
      if (do_remove) begin
        head_r[rem_lvl] <= rem_head_nxt;
        if (rem_head_nxt == tail_r[rem_lvl]) begin
          nonempty_r[rem_lvl] <= 1'b0;
        end
      end
    end
  end

  // Result stage: one transfer per accepted command, the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      out_take_r   <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      out_take_r   <= do_remove;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level_r <= do_remove ? LEVEL_W'(rem_lvl) : '0;
      if (is_remove) begin
        out_status_r <= rem_found ? ST_OK : ST_EMPTY;
      end else begin
        out_status_r <= ins_ok ? ST_OK : ST_FULL;
      end
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_taken_value = out_take_r ? ram_rdata : '0;
  assign out_taken_level = out_level_r;
  assign out_status      = out_status_r;

endmodule
